/* rtl/pctbl_pkg.sv */
// ----------------------------------------------------------------------------
// pctbl_pkg
// Shared types and constants of the per-client token bucket limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package pctbl_pkg;

  localparam int RATE_FRAC_BITS = 24;
  localparam int TIME_W         = 32;
  localparam int LEVEL_W        = 32;
  localparam int CAP_W          = 16;
  localparam int CFG_W          = 32;

  typedef enum logic [1:0] {
    REG_TOKEN_CAPACITY  = 2'd0,
    REG_REFILL_PER_TICK = 2'd1,
    REG_SWEEP_INTERVAL  = 2'd2,
    REG_IDLE_THRESHOLD  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] tokens;
    logic [TIME_W-1:0]  last_request;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* rtl/pctbl_ram.sv */
// ----------------------------------------------------------------------------
// pctbl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pctbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/per_client_token_bucket_limiter_unit.sv */
// ----------------------------------------------------------------------------
// per_client_token_bucket_limiter_unit
// Per-client token bucket rate limiter with lazy idle-entry expiry.
// ----------------------------------------------------------------------------
// After reset the unit clears its bucket table, one entry per cycle, with busy
// high. An item is taken when start is high and busy is low. A request with an
// absent key is answered on the next cycle and busy stays low. Any other
// request keeps busy high through entry check and elapsed time, refill
// multiply, saturation and write-back, and its result is registered in the
// write-back step. Each result is shown for one cycle with out_valid high and
// cannot be held off. Configuration is written whenever cfg_we is high; write
// it only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module per_client_token_bucket_limiter_unit
  import pctbl_pkg::*;
#(
  parameter int CLIENT_SLOTS    = 256,
  parameter int TOKEN_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [7:0]         in_client_slot,
  input  wire logic               in_key_absent,
  input  wire logic [TIME_W-1:0]  in_time_now,
  output logic                    out_valid,
  output logic                    out_allow,
  output logic [LEVEL_W-1:0]      out_tokens_left,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_wdata
);

  localparam int SLOT_W     = $clog2(CLIENT_SLOTS);
  localparam int RATE_SHIFT = RATE_FRAC_BITS - TOKEN_FRAC_BITS;
  localparam int MOD_W      = 25;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MUL,
    S_SAT,
    S_WB
  } state_t;

  // configuration
  logic [CAP_W-1:0]  token_capacity_r;
  logic [CFG_W-1:0]  refill_per_tick_r;
  logic [CFG_W-1:0]  sweep_interval_r;
  logic [CFG_W-1:0]  idle_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_capacity_r  <= CAP_W'(10);
      refill_per_tick_r <= 32'd168;
      sweep_interval_r  <= 32'd60000000;
      idle_threshold_r  <= 32'd300000000;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TOKEN_CAPACITY:  token_capacity_r  <= cfg_wdata[CAP_W-1:0];
        REG_REFILL_PER_TICK: refill_per_tick_r <= cfg_wdata;
        REG_SWEEP_INTERVAL:  sweep_interval_r  <= cfg_wdata;
        REG_IDLE_THRESHOLD:  idle_threshold_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // fixed-point capacity and one token
  logic [47:0]        cap_wide;
  logic [LEVEL_W-1:0] capf;
  logic [LEVEL_W-1:0] one_tok;
  logic [LEVEL_W-1:0] start_lvl;

  always_comb begin
    cap_wide  = {32'b0, token_capacity_r} << TOKEN_FRAC_BITS;
    capf      = (|cap_wide[47:32]) ? {LEVEL_W{1'b1}} : cap_wide[31:0];
    one_tok   = LEVEL_W'(1) << TOKEN_FRAC_BITS;
    start_lvl = (capf >= one_tok) ? (capf - one_tok) : '0;
  end

  // slot modulo table depth
  logic [MOD_W-1:0]  slot_rem;
  logic [SLOT_W-1:0] slot_idx;

  always_comb begin
    slot_rem = MOD_W'(in_client_slot);
    for (int k = 7; k >= 0; k--) begin
      if (slot_rem >= (MOD_W'(CLIENT_SLOTS) << k)) begin
        slot_rem = slot_rem - (MOD_W'(CLIENT_SLOTS) << k);
      end
    end
    slot_idx = slot_rem[SLOT_W-1:0];
  end

  // state and datapath registers
  state_t             state_r, state_nxt;
  logic [SLOT_W-1:0]  clr_r, clr_nxt;
  logic [TIME_W-1:0]  sweep_r, sweep_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic               gone_r, gone_nxt;
  logic [LEVEL_W-1:0] lvl_r, lvl_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_allow_r, out_allow_nxt;
  logic [LEVEL_W-1:0] out_tokens_r, out_tokens_nxt;

  // table
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_rdata;

  assign rd_entry = entry_t'(ram_rdata);

  pctbl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CLIENT_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (slot_idx),
    .rdata (ram_rdata)
  );

  logic [TIME_W-1:0]  age_req;
  logic [TIME_W-1:0]  age_sweep;
  logic [TIME_W-1:0]  sweep_gap;
  logic [63:0]        inc;
  logic [LEVEL_W-1:0] head;
  logic               sat;
  logic               ok;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    sweep_nxt      = sweep_r;
    slot_nxt       = slot_r;
    now_nxt        = now_r;
    gone_nxt       = gone_r;
    lvl_nxt        = lvl_r;
    elapsed_nxt    = elapsed_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = 1'b0;
    out_allow_nxt  = out_allow_r;
    out_tokens_nxt = out_tokens_r;
    ram_we         = 1'b0;
    ram_waddr      = slot_r;
    wr_entry       = '0;

    age_req   = now_r - rd_entry.last_request;
    age_sweep = now_r - sweep_r;
    sweep_gap = sweep_r - rd_entry.last_request;
    inc       = prod_r >> RATE_SHIFT;
    head      = capf - lvl_r;
    sat       = (lvl_r >= capf) || (inc >= {32'b0, head});
    ok        = lvl_r >= one_tok;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + SLOT_W'(1);
        if (clr_r == SLOT_W'(CLIENT_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_key_absent) begin
            out_valid_nxt  = 1'b1;
            out_allow_nxt  = 1'b0;
            out_tokens_nxt = capf;
          end else begin
            // advance the sweep clock
            if ((in_time_now - sweep_r) > sweep_interval_r) begin
              sweep_nxt = in_time_now;
            end
            slot_nxt  = slot_idx;
            now_nxt   = in_time_now;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        gone_nxt    = !rd_entry.valid ||
                      ((age_req > age_sweep) && (sweep_gap > idle_threshold_r));
        lvl_nxt     = rd_entry.tokens;
        elapsed_nxt = now_r - rd_entry.last_request;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = elapsed_r * refill_per_tick_r;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if (gone_r) begin
          lvl_nxt = start_lvl;
        end else if (sat) begin
          lvl_nxt = capf;
        end else begin
          lvl_nxt = lvl_r + inc[LEVEL_W-1:0];
        end
        state_nxt = S_WB;
      end
      S_WB: begin
        ram_we                = 1'b1;
        wr_entry.valid        = 1'b1;
        wr_entry.last_request = now_r;
        out_valid_nxt         = 1'b1;
        out_tokens_nxt        = lvl_r;
        if (gone_r) begin
          out_allow_nxt   = 1'b1;
          wr_entry.tokens = lvl_r;
        end else begin
          out_allow_nxt   = ok;
          wr_entry.tokens = ok ? (lvl_r - one_tok) : lvl_r;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    now_r        <= now_nxt;
    gone_r       <= gone_nxt;
    lvl_r        <= lvl_nxt;
    elapsed_r    <= elapsed_nxt;
    prod_r       <= prod_nxt;
    out_allow_r  <= out_allow_nxt;
    out_tokens_r <= out_tokens_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_allow       = out_allow_r;
  assign out_tokens_left = out_tokens_r;

endmodule

`default_nettype wire

/* rtl/pctbl_checker.sv */
// ----------------------------------------------------------------------------
// pctbl_checker
// Port-level checks of the limiter's item timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pctbl_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_key_absent,
  input wire logic out_valid,
  input wire logic out_allow
);

  logic take;

  assign take = start && !busy;

  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  a_absent_answer: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_key_absent |=> out_valid && !out_allow)
    else $error("absent key not denied on next cycle");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take && !in_key_absent |=> busy && !out_valid)
    else $error("lookup item did not hold busy");

  a_lookup_result: assert property (@(posedge clk) disable iff (!rst_n)
    take && !in_key_absent |-> ##5 (out_valid && !busy))
    else $error("lookup result missing");

endmodule

bind per_client_token_bucket_limiter_unit pctbl_checker u_pctbl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_key_absent (in_key_absent),
  .out_valid     (out_valid),
  .out_allow     (out_allow)
);

`default_nettype wire
